// ===== hw/rtl/ftar_pkg.sv =====
package ftar_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_BITS  = 16;
    localparam int ADDR_BITS    = 10;
    localparam int COL_BITS     = 11;
    localparam int STEP_BITS    = 16;
    localparam int FRAC_SQ      = 31 - HEIGHT_BITS;
    localparam int DIFF_BITS    = 16;
    localparam int SQ_BITS      = 33;
    localparam int RAD_BITS     = 64;
    localparam int ROOT_BITS    = 32;
    localparam int REM_BITS     = 34;
    localparam int XY_BITS      = 46;
    localparam int NORM_EXP     = 40;
    localparam int Z_BITS       = 23;
    localparam int ANGLE_BITS   = 15;
    localparam int CORDIC_STEPS = 20;
    localparam int SQRT_STEPS   = 32;
    localparam int CNT_BITS     = 5;

    localparam logic [COL_BITS-1:0]   ROW_WIDTH_RESET = 11'd1024;
    localparam logic [STEP_BITS-1:0]  GRID_STEP_RESET = 16'd1;
    localparam logic [COL_BITS-1:0]   MIN_ROW_WIDTH   = 11'd2;
    localparam logic [COL_BITS-1:0]   MAX_ROW_WIDTH   = 11'd1024;
    localparam logic [Z_BITS-1:0]     Z_CLAMP_HI      = 23'd1647104;
    localparam logic [ANGLE_BITS-1:0] PI_Q13          = 15'd25736;

    // Register index, taken from address bit 2
    localparam logic REG_ROW_WIDTH = 1'b0;
    localparam logic REG_GRID_STEP = 1'b1;

    typedef struct packed {
        logic signed [HEIGHT_BITS-1:0] height;
        logic                          frame_start;
    } ftar_in_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle;
        logic                  second_facet;
    } ftar_out_t;

    typedef struct packed {
        logic                capture;
        logic                load;
        logic                sq_a;
        logic                sq_b;
        logic                sqrt_init;
        logic                sqrt_step;
        logic                norm_init;
        logic                norm_step;
        logic                cordic_step;
        logic                facet;
        logic [CNT_BITS-1:0] step;
    } ftar_cmd_t;

    typedef struct packed {
        logic cell_ok;
        logic norm_done;
    } ftar_stat_t;

    // round(atan(2^-i) * 2^20)
    function automatic logic [19:0] atan_q20(input logic [CNT_BITS-1:0] i);
        logic [19:0] v;
        case (i)
            5'd0:    v = 20'd823550;
            5'd1:    v = 20'd486170;
            5'd2:    v = 20'd256879;
            5'd3:    v = 20'd130396;
            5'd4:    v = 20'd65451;
            5'd5:    v = 20'd32757;
            5'd6:    v = 20'd16383;
            5'd7:    v = 20'd8192;
            5'd8:    v = 20'd4096;
            5'd9:    v = 20'd2048;
            5'd10:   v = 20'd1024;
            5'd11:   v = 20'd512;
            5'd12:   v = 20'd256;
            5'd13:   v = 20'd128;
            5'd14:   v = 20'd64;
            5'd15:   v = 20'd32;
            5'd16:   v = 20'd16;
            5'd17:   v = 20'd8;
            5'd18:   v = 20'd4;
            5'd19:   v = 20'd2;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/facet_tilt_angle_raster.sv =====
// A sample that closes no cell (row 0, column 0, frame start) only updates the line store and position.
// A sample that closes a cell runs, per facet, two squaring passes, 32 square-root
// digit steps, 9 to 25 normalize shifts and 20 CORDIC iterations on one shared
// datapath, then waits for a free output slot; no new sample is taken until it ends.
// Reset (aresetn low, synchronous) clears the controller, row/column position and
// neighbor samples; the line store is not cleared and holds data only once written.
module facet_tilt_angle_raster (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ftar_pkg::ftar_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ftar_pkg::ftar_out_t  m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [ftar_pkg::COL_BITS-1:0]   row_width_reg;
    logic [ftar_pkg::STEP_BITS-1:0]  grid_step_reg;
    logic                            m_valid_reg;
    ftar_pkg::ftar_out_t             m_data_reg;
    ftar_pkg::ftar_cmd_t             cmd;
    ftar_pkg::ftar_stat_t            stat;
    logic                            out_free;
    logic                            emit;
    logic [ftar_pkg::ANGLE_BITS-1:0] angle;

    // Configuration: register index sits in address bit 2, zero wait states.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ftar_pkg::ROW_WIDTH_RESET;
            grid_step_reg <= ftar_pkg::GRID_STEP_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                ftar_pkg::REG_ROW_WIDTH: row_width_reg <= pwdata[ftar_pkg::COL_BITS-1:0];
                ftar_pkg::REG_GRID_STEP: grid_step_reg <= pwdata[ftar_pkg::STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ftar_pkg::REG_ROW_WIDTH: prdata = 32'(row_width_reg);
            ftar_pkg::REG_GRID_STEP: prdata = 32'(grid_step_reg);
            default:                 prdata = '0;
        endcase
    end

    // Output register: hold a result until taken; refill once the slot drains.
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg.angle        <= angle;
            m_data_reg.second_facet <= cmd.facet;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Sequencer: accepts a request in idle, then walks both facets if the sample closes a cell.
    ftar_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .emit     (emit),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Line store, neighbor samples, squarer, square root and CORDIC.
    ftar_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_data),
        .row_width (row_width_reg),
        .grid_step (grid_step_reg),
        .cmd       (cmd),
        .stat      (stat),
        .angle     (angle)
    );

endmodule

// ===== hw/rtl/ftar_ctrl.sv =====
module ftar_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               out_free,
    output logic               emit,
    output ftar_pkg::ftar_cmd_t cmd,
    input  ftar_pkg::ftar_stat_t stat
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_SQA, ST_SQB, ST_SQINIT, ST_SQRT,
        ST_NINIT, ST_NORM, ST_CORD, ST_EMIT
    } state_t;

    state_t                        state_reg, state_next;
    logic [ftar_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                          facet_reg, facet_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        facet_next = facet_reg;
        cmd        = '0;
        cmd.facet  = facet_reg;
        cmd.step   = cnt_reg;
        s_ready    = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                facet_next = 1'b0;
                state_next = stat.cell_ok ? ST_SQA : ST_IDLE;
            end
            ST_SQA: begin
                cmd.sq_a   = 1'b1;
                state_next = ST_SQB;
            end
            ST_SQB: begin
                cmd.sq_b   = 1'b1;
                state_next = ST_SQINIT;
            end
            ST_SQINIT: begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == ftar_pkg::CNT_BITS'(ftar_pkg::SQRT_STEPS - 1)) begin
                    state_next = ST_NINIT;
                end
            end
            ST_NINIT: begin
                cmd.norm_init = 1'b1;
                state_next    = ST_NORM;
            end
            ST_NORM: begin
                cnt_next = '0;
                if (stat.norm_done) begin
                    state_next = ST_CORD;
                end else begin
                    cmd.norm_step = 1'b1;
                end
            end
            ST_CORD: begin
                cmd.cordic_step = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == ftar_pkg::CNT_BITS'(ftar_pkg::CORDIC_STEPS - 1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (facet_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        facet_next = 1'b1;
                        state_next = ST_SQA;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            facet_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            facet_reg <= facet_next;
        end
    end

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free) else $error("result emitted into a full output slot");
    a_no_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD && !stat.cell_ok) |=> state_reg == ST_IDLE)
        else $error("edge sample did not return to idle");
    a_last_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && facet_reg) |=> (state_reg == ST_IDLE && s_ready))
        else $error("second facet did not end the cell");
    a_cord_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CORD |-> cnt_reg < ftar_pkg::CNT_BITS'(ftar_pkg::CORDIC_STEPS))
        else $error("cordic step count overrun");
`endif

endmodule

// ===== hw/rtl/ftar_datapath.sv =====
module ftar_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ftar_pkg::ftar_in_t                  in_data,
    input  logic [ftar_pkg::COL_BITS-1:0]       row_width,
    input  logic [ftar_pkg::STEP_BITS-1:0]      grid_step,
    input  ftar_pkg::ftar_cmd_t                 cmd,
    output ftar_pkg::ftar_stat_t                stat,
    output logic [ftar_pkg::ANGLE_BITS-1:0]     angle
);

    logic signed [ftar_pkg::HEIGHT_BITS-1:0] line_store [ftar_pkg::MAX_WIDTH];
    logic signed [ftar_pkg::HEIGHT_BITS-1:0] mem_q_reg;
    logic signed [ftar_pkg::HEIGHT_BITS-1:0] cur_reg, left_reg, ul_reg;
    logic [ftar_pkg::ADDR_BITS-1:0]          col_reg, c_reg;
    logic                                    frd_reg;

    logic [ftar_pkg::DIFF_BITS-1:0] ua0_reg, ub0_reg, ua1_reg, ub1_reg;
    logic [ftar_pkg::SQ_BITS-1:0]   d_reg;
    logic [ftar_pkg::RAD_BITS-1:0]  v_reg;
    logic [ftar_pkg::ROOT_BITS-1:0] r_reg;
    logic [ftar_pkg::REM_BITS-1:0]  rem_reg;
    logic signed [ftar_pkg::XY_BITS-1:0] x_reg, y_reg;
    logic signed [ftar_pkg::Z_BITS-1:0]  z_reg;

    logic [ftar_pkg::ADDR_BITS-1:0]       c_in;
    logic [ftar_pkg::COL_BITS-1:0]        width_sat;
    logic [ftar_pkg::STEP_BITS-1:0]       s_eff;
    logic [ftar_pkg::DIFF_BITS-1:0]       op_a;
    logic [2*ftar_pkg::DIFF_BITS-1:0]     prod;
    logic [ftar_pkg::REM_BITS+1:0]        cand, trial;
    logic signed [ftar_pkg::XY_BITS-1:0]  xs, ys;
    logic signed [ftar_pkg::Z_BITS-1:0]   at;
    logic [ftar_pkg::Z_BITS-1:0]          zc;
    logic [ftar_pkg::Z_BITS-1:0]          zr;
    logic [ftar_pkg::ANGLE_BITS-1:0]      tilt;

    function automatic logic [ftar_pkg::DIFF_BITS-1:0] abs_diff(
        input logic signed [ftar_pkg::HEIGHT_BITS-1:0] p,
        input logic signed [ftar_pkg::HEIGHT_BITS-1:0] q
    );
        logic signed [ftar_pkg::HEIGHT_BITS:0] d;
        d = {p[ftar_pkg::HEIGHT_BITS-1], p} - {q[ftar_pkg::HEIGHT_BITS-1], q};
        return d[ftar_pkg::HEIGHT_BITS] ? ftar_pkg::DIFF_BITS'(-d)
                                        : ftar_pkg::DIFF_BITS'(d);
    endfunction

    assign c_in = in_data.frame_start ? '0 : col_reg;
    assign s_eff = (grid_step == '0) ? ftar_pkg::STEP_BITS'(1) : grid_step;

    always_comb begin
        if (row_width < ftar_pkg::MIN_ROW_WIDTH) begin
            width_sat = ftar_pkg::MIN_ROW_WIDTH;
        end else if (row_width > ftar_pkg::MAX_ROW_WIDTH) begin
            width_sat = ftar_pkg::MAX_ROW_WIDTH;
        end else begin
            width_sat = row_width;
        end
    end

    // one shared squarer: a on the first pass, b on the second
    always_comb begin
        if (cmd.sq_a) begin
            op_a = cmd.facet ? ua1_reg : ua0_reg;
        end else begin
            op_a = cmd.facet ? ub1_reg : ub0_reg;
        end
    end
    assign prod = op_a * op_a;

    assign cand  = {rem_reg, v_reg[ftar_pkg::RAD_BITS-1 -: 2]};
    assign trial = cand - {2'b00, r_reg, 2'b01};

    assign xs = x_reg >>> cmd.step;
    assign ys = y_reg >>> cmd.step;
    assign at = ftar_pkg::Z_BITS'(ftar_pkg::atan_q20(cmd.step));

    assign stat.cell_ok   = (c_reg != '0) && frd_reg;
    assign stat.norm_done = (x_reg[ftar_pkg::XY_BITS-1:ftar_pkg::NORM_EXP] != '0) ||
                            (y_reg[ftar_pkg::XY_BITS-1:ftar_pkg::NORM_EXP] != '0);

    // clamp to 0..pi/2, round Q20 to Q13
    always_comb begin
        if (z_reg < 0) begin
            zc = '0;
        end else if (z_reg > $signed(ftar_pkg::Z_CLAMP_HI)) begin
            zc = ftar_pkg::Z_CLAMP_HI;
        end else begin
            zc = z_reg;
        end
        zr    = zc + ftar_pkg::Z_BITS'(64);
        tilt  = ftar_pkg::ANGLE_BITS'(zr >> 7);
        angle = cmd.facet ? (ftar_pkg::PI_Q13 - tilt) : tilt;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mem_q_reg <= line_store[c_in];
        end
        if (cmd.load) begin
            line_store[c_reg] <= cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            frd_reg  <= 1'b0;
            left_reg <= '0;
            ul_reg   <= '0;
        end else if (cmd.capture) begin
            if (in_data.frame_start) begin
                frd_reg <= 1'b0;
            end
        end else if (cmd.load) begin
            ul_reg   <= mem_q_reg;
            left_reg <= cur_reg;
            if ({1'b0, c_reg} + 1'b1 >= width_sat) begin
                col_reg <= '0;
                frd_reg <= 1'b1;
            end else begin
                col_reg <= c_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cur_reg <= in_data.height;
            c_reg   <= c_in;
        end
        if (cmd.load) begin
            ua0_reg <= abs_diff(mem_q_reg, ul_reg);
            ub0_reg <= abs_diff(left_reg, ul_reg);
            ua1_reg <= abs_diff(mem_q_reg, cur_reg);
            ub1_reg <= abs_diff(left_reg, cur_reg);
        end
        if (cmd.sq_a) begin
            d_reg <= ftar_pkg::SQ_BITS'(prod);
        end
        if (cmd.sq_b) begin
            d_reg <= d_reg + ftar_pkg::SQ_BITS'(prod);
        end
        if (cmd.sqrt_init) begin
            v_reg   <= ftar_pkg::RAD_BITS'({d_reg, {(2*ftar_pkg::FRAC_SQ){1'b0}}});
            r_reg   <= '0;
            rem_reg <= '0;
        end
        if (cmd.sqrt_step) begin
            v_reg <= v_reg << 2;
            if (!trial[ftar_pkg::REM_BITS+1]) begin
                rem_reg <= trial[ftar_pkg::REM_BITS-1:0];
                r_reg   <= {r_reg[ftar_pkg::ROOT_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= cand[ftar_pkg::REM_BITS-1:0];
                r_reg   <= {r_reg[ftar_pkg::ROOT_BITS-2:0], 1'b0};
            end
        end
        if (cmd.norm_init) begin
            x_reg <= ftar_pkg::XY_BITS'({s_eff, {ftar_pkg::FRAC_SQ{1'b0}}});
            y_reg <= ftar_pkg::XY_BITS'(r_reg);
            z_reg <= '0;
        end
        if (cmd.norm_step && !stat.norm_done) begin
            x_reg <= x_reg <<< 1;
            y_reg <= y_reg <<< 1;
        end
        if (cmd.cordic_step) begin
            if (!y_reg[ftar_pkg::XY_BITS-1]) begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end else begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int SETTLE_CYCLES = 400;   // longer than the slowest cell

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    ftar_pkg::ftar_in_t  s_data;
    logic                m_valid;
    logic                m_ready;
    ftar_pkg::ftar_out_t m_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    facet_tilt_angle_raster dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Requests waiting for the driver, and angles the block still owes us
    ftar_pkg::ftar_in_t  pending_samples[$];
    ftar_pkg::ftar_out_t expected_angles[$];
    int        errors = 0;
    logic      s_took;
    int        s_gap;
    int        m_gap;
    bit        no_idle;

    // Shadow of the raster state and registers
    logic signed [15:0] row_buf[ftar_pkg::MAX_WIDTH];
    logic signed [15:0] left_h;
    logic signed [15:0] upleft_h;
    int unsigned        col_pos;
    bit                 row0_done;
    logic [10:0]        cfg_width;
    logic [15:0]        cfg_step;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Safety net: far beyond the slowest legal run
    initial begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic longint unsigned abs_delta(int p, int q);
        longint d;
        d = longint'(p) - longint'(q);
        return d < 0 ? longint'(-d) : longint'(d);
    endfunction

    // atan(sqrt(a^2+b^2)/s) in Q13 via integer root and CORDIC vectoring
    function automatic logic [14:0] facet_tilt(longint unsigned ua, longint unsigned ub,
                                               int unsigned s);
        longint unsigned v, root, bitv;
        longint x, y, z, xs, ys;
        logic [19:0] lut[20];
        lut = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
                1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
        v = (ua * ua + ub * ub) << (2 * ftar_pkg::FRAC_SQ);
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        y = longint'(root);
        x = longint'(longint'(s) << ftar_pkg::FRAC_SQ);
        z = 0;
        // Scale both legs up until the larger one reaches 2^40
        while (x < (64'sd1 <<< ftar_pkg::NORM_EXP) && y < (64'sd1 <<< ftar_pkg::NORM_EXP)) begin
            x = x <<< 1;
            y = y <<< 1;
        end
        for (int i = 0; i < ftar_pkg::CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(lut[i]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(lut[i]);
            end
        end
        if (z < 0) z = 0;
        if (z > 1647104) z = 1647104;
        return 15'((z + 64) >>> 7);
    endfunction

    // Advance the shadow raster by one accepted sample and queue its angles
    task automatic predict_cell(input ftar_pkg::ftar_in_t smp);
        int unsigned width, step, c;
        logic signed [15:0] up;
        logic [14:0] t1, t2;
        ftar_pkg::ftar_out_t r;
        width = cfg_width;
        step = (cfg_step == 0) ? 1 : cfg_step;
        if (width < 2) width = 2;
        if (width > ftar_pkg::MAX_WIDTH) width = ftar_pkg::MAX_WIDTH;
        if (smp.frame_start) begin
            col_pos = 0;
            row0_done = 0;
        end
        c = col_pos % ftar_pkg::MAX_WIDTH;
        up = row_buf[c];
        if (c >= 1 && row0_done) begin
            t1 = facet_tilt(abs_delta(up, upleft_h), abs_delta(left_h, upleft_h), step);
            t2 = facet_tilt(abs_delta(up, smp.height), abs_delta(left_h, smp.height), step);
            r.angle = t1;
            r.second_facet = 1'b0;
            expected_angles = {expected_angles, r};
            r.angle = ftar_pkg::PI_Q13 - t2;
            r.second_facet = 1'b1;
            expected_angles = {expected_angles, r};
        end
        upleft_h = up;
        row_buf[c] = smp.height;
        left_h = smp.height;
        if (c + 1 >= width) begin
            col_pos = 0;
            row0_done = 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    // Mark acceptance for the driver; predict each request as it is taken
    always @(posedge aclk) begin
        s_took <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) predict_cell(s_data);
    end

    // Driver: hold the request until taken, then advance after a random gap
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (s_gap > 0) begin
                s_valid <= 1'b0;
                s_gap <= s_gap - 1;
            end else if (pending_samples.size() > 0) begin
                s_data <= pending_samples.pop_front();
                s_valid <= 1'b1;
                s_gap <= gap_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(negedge aclk) begin
        if (m_gap > 0) begin
            m_ready <= 1'b0;
            m_gap <= m_gap - 1;
        end else begin
            m_ready <= 1'b1;
            m_gap <= gap_len();
        end
    end

    // Monitor: compare each taken result with the oldest expected angle
    always @(posedge aclk) begin
        ftar_pkg::ftar_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_angles.size() == 0) begin
                errors++;
                $display("%0t: unexpected result angle=%0d second=%0d", $time,
                         m_data.angle, m_data.second_facet);
            end else begin
                e = expected_angles.pop_front();
                if (m_data.angle !== e.angle) begin
                    errors++;
                    $display("%0t: angle expected %0d actual %0d", $time, e.angle,
                             m_data.angle);
                end
                if (m_data.second_facet !== e.second_facet) begin
                    errors++;
                    $display("%0t: second_facet expected %0d actual %0d", $time,
                             e.second_facet, m_data.second_facet);
                end
            end
        end
    end

    task automatic bus_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Drain everything, then give any sample without results time to finish
    task automatic wait_drained();
        while (pending_samples.size() > 0 || s_valid || expected_angles.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic push_sample(input int h, input bit fs);
        ftar_pkg::ftar_in_t it;
        it.height = 16'(h);
        it.frame_start = fs;
        pending_samples = {pending_samples, it};
    endtask

    // Random heights: smooth surfaces mostly, with jumps and extremes
    task automatic push_surface(input int n, input bit fs_first);
        int h, r;
        h = $urandom_range(0, 65535) - 32768;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 25) h = $urandom_range(0, 65535) - 32768;
            else if (r < 35) h = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            else h = h + $urandom_range(0, 128) - 64;
            if (h > 32767) h = 32767;
            if (h < -32768) h = -32768;
            push_sample(h, (i == 0 && fs_first) || ($urandom_range(0, 99) < 2));
        end
    endtask

    // Reconfigure once drained and idle; the caller then feeds one stretch of raster
    task automatic setup_raster(input logic [31:0] width, input logic [31:0] step);
        wait_drained();
        no_idle = ($urandom_range(0, 3) == 0);
        bus_write(3'd0, width);
        bus_write(3'd4, step);
        cfg_width = width[10:0];
        cfg_step = step[15:0];
    endtask

    initial begin
        int w;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_took = 1'b0;
        s_gap = 0;
        m_gap = 0;
        no_idle = 0;
        for (int i = 0; i < ftar_pkg::MAX_WIDTH; i++) row_buf[i] = '0;
        left_h = '0;
        upleft_h = '0;
        col_pos = 0;
        row0_done = 0;
        cfg_width = ftar_pkg::ROW_WIDTH_RESET;
        cfg_step = ftar_pkg::GRID_STEP_RESET;
        repeat (12) @(posedge aclk);
        aresetn = 1'b1;

        // Flat cells, then full-scale swings at the narrowest step
        setup_raster(3, 1);
        push_sample(0, 1); push_sample(0, 0); push_sample(0, 0);
        push_sample(0, 0); push_sample(0, 0); push_sample(0, 0);
        push_sample(32767, 0); push_sample(-32768, 0); push_sample(32767, 0);
        push_sample(-32768, 0); push_sample(32767, 0); push_sample(-32768, 0);
        // Frame start mid-row restarts at row 0
        push_sample(100, 1); push_sample(-100, 0); push_sample(5, 0);
        push_sample(7, 0); push_sample(9, 0);

        // Width below range saturates to 2, zero step acts as 1
        setup_raster(0, 0);
        push_sample(0, 1); push_sample(1, 0); push_sample(-1, 0); push_sample(2, 0);

        // Widest step, full-scale height changes
        setup_raster(1, 65535);
        push_sample(-32768, 1); push_sample(32767, 0); push_sample(0, 0);
        push_sample(1, 0);

        // Shrink the row width mid-row without a frame start: row wraps early
        setup_raster(5, 3);
        push_surface(8, 1);
        setup_raster(3, 3);
        push_surface(8, 0);

        // Random rasters, mostly narrow
        for (int p = 0; p < 10; p++) begin
            w = ($urandom_range(0, 1) != 0) ? $urandom_range(2, 8) : $urandom_range(2, 40);
            case ($urandom_range(0, 3))
                0: setup_raster(w, $urandom_range(0, 1) != 0 ? 65535 : 0);
                1: setup_raster(w, $urandom_range(1, 16));
                default: setup_raster(w, $urandom_range(1, 65535));
            endcase
            push_surface(90, 1);
        end

        // Width above range saturates to the full 1024-sample line
        setup_raster(2047, $urandom_range(1, 300));
        push_surface(1040, 1);

        wait_drained();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== facet_tilt_angle_raster.f =====
hw/rtl/ftar_pkg.sv
hw/rtl/ftar_ctrl.sv
hw/rtl/ftar_datapath.sv
hw/rtl/facet_tilt_angle_raster.sv
test/tb_top.sv
